### rtl/core/mbshr_pkg.sv
// ----------------------------------------------------------------------------
// mbshr_pkg
// Types, codes and helper functions shared by the holding-register engine.
// ----------------------------------------------------------------------------
package mbshr_pkg;

  // request codes on the input channel
  localparam logic [1:0] REQ_LINK = 2'd0;
  localparam logic [1:0] REQ_HWR  = 2'd1;
  localparam logic [1:0] REQ_HRD  = 2'd2;

  // result kinds on the output channel
  localparam logic [1:0] KIND_TX   = 2'd0;
  localparam logic [1:0] KIND_HOST = 2'd1;
  localparam logic [1:0] KIND_NOTE = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_SLAVE_ID = 3'd0;
  localparam logic [2:0] CFG_TCP_MODE = 3'd1;
  localparam logic [2:0] CFG_W0_BASE  = 3'd2;
  localparam logic [2:0] CFG_W0_SIZE  = 3'd3;
  localparam logic [2:0] CFG_W1_BASE  = 3'd4;
  localparam logic [2:0] CFG_W1_SIZE  = 3'd5;

  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  localparam logic [7:0] FN_READ  = 8'h03;
  localparam logic [7:0] FN_WRITE = 8'h06;
  localparam logic [7:0] FN_WMC   = 8'h0F;
  localparam logic [7:0] FN_WMR   = 8'h10;
  localparam logic [7:0] EXC_FLAG = 8'h80;
  localparam logic [7:0] EXC_FUNC = 8'h01;
  localparam logic [7:0] EXC_ADDR = 8'h02;

  localparam int HDR_DEPTH = 14;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_HOUT, ST_CHECK, ST_DECIDE, ST_NOTE,
    ST_MBAP, ST_PDU, ST_RDREQ, ST_DHI, ST_DLO, ST_CRC
  } state_e;

  typedef enum logic [2:0] {
    SEL_HDR, SEL_LEN_HI, SEL_LEN_LO, SEL_PDU,
    SEL_DHI, SEL_DLO, SEL_CRC_LO, SEL_CRC_HI
  } sel_e;

  typedef enum logic [1:0] {
    CLS_EXC, CLS_READ, CLS_WRITE
  } cls_e;

  typedef struct packed {
    logic       clr_step;
    logic       link_acc;
    logic       host_wr;
    logic       host_rd;
    logic       latch;
    logic       note_wr;
    logic       rd_req;
    logic       emit;
    logic [1:0] kind;
    sel_e       sel;
    logic       last;
    logic       crc_upd;
    logic [7:0] idx;
  } cmd_t;

  typedef struct packed {
    logic       clr_done;
    logic       ok;
    cls_e       cls;
    logic       tcp;
    logic [7:0] nregs;
    logic       can_emit;
  } stat_t;

  // CRC-16, reflected, one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### rtl/core/mbshr_if.sv
// ----------------------------------------------------------------------------
// mbshr_if
// Valid/ready channels: request items in, result items out.
// ----------------------------------------------------------------------------
interface mbshr_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [7:0]  rx_byte;
  logic        rx_last;
  logic [4:0]  host_index;
  logic [15:0] host_data;

  modport source (output valid, req_type, rx_byte, rx_last, host_index, host_data,
                  input ready);
  modport sink (input valid, req_type, rx_byte, rx_last, host_index, host_data,
                output ready);
endinterface

interface mbshr_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_kind;
  logic [7:0]  tx_byte;
  logic        tx_last;
  logic [15:0] reg_value;
  logic [4:0]  reg_index;

  modport source (output valid, out_kind, tx_byte, tx_last, reg_value, reg_index,
                  input ready);
  modport sink (input valid, out_kind, tx_byte, tx_last, reg_value, reg_index,
                output ready);
endinterface

### rtl/core/mbshr_ram.sv
// ----------------------------------------------------------------------------
// mbshr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mbshr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/mbshr_ctrl.sv
// ----------------------------------------------------------------------------
// mbshr_ctrl
// Sequencer: takes requests, steps through frame check and response bytes.
// ----------------------------------------------------------------------------
module mbshr_ctrl import mbshr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] req_type_i,
  input  logic       rx_last_i,
  output logic       in_ready_o,
  input  stat_t      stat_i,
  output cmd_t       cmd_o
);

  state_e     state_q, state_d;
  logic [7:0] idx_q, idx_d;
  logic       head_end;
  logic       last_reg;
  logic       has_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  assign head_end = (stat_i.cls == CLS_WRITE) ? (idx_q == 8'd5) : (idx_q == 8'd2);
  assign last_reg = (({1'b0, idx_q} + 9'd1) == {1'b0, stat_i.nregs});
  assign has_data = (stat_i.cls == CLS_READ) && (stat_i.nregs != 8'd0);

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    cmd_o      = '0;
    cmd_o.sel  = SEL_HDR;
    cmd_o.kind = KIND_TX;
    cmd_o.idx  = idx_q;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = !stat_i.clr_done;
        if (stat_i.clr_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (req_type_i)
            REQ_LINK: begin
              cmd_o.link_acc = 1'b1;
              if (rx_last_i) state_d = ST_CHECK;
            end
            REQ_HWR: cmd_o.host_wr = 1'b1;
            REQ_HRD: begin
              cmd_o.host_rd = 1'b1;
              state_d       = ST_HOUT;
            end
            default: ;
          endcase
        end
      end
      ST_HOUT: begin
        cmd_o.kind = KIND_HOST;
        if (stat_i.can_emit) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_CHECK: begin
        cmd_o.latch = 1'b1;
        state_d     = ST_DECIDE;
      end
      ST_DECIDE: begin
        idx_d = '0;
        if (!stat_i.ok) state_d = ST_IDLE;
        else if (stat_i.cls == CLS_WRITE) state_d = ST_NOTE;
        else if (stat_i.tcp) state_d = ST_MBAP;
        else state_d = ST_PDU;
      end
      ST_NOTE: begin
        cmd_o.kind = KIND_NOTE;
        if (stat_i.can_emit) begin
          cmd_o.emit    = 1'b1;
          cmd_o.note_wr = 1'b1;
          state_d       = stat_i.tcp ? ST_MBAP : ST_PDU;
        end
      end
      ST_MBAP: begin
        cmd_o.sel = (idx_q == 8'd4) ? SEL_LEN_HI : (idx_q == 8'd5) ? SEL_LEN_LO : SEL_HDR;
        if (stat_i.can_emit) begin
          cmd_o.emit = 1'b1;
          if (idx_q == 8'd5) begin
            idx_d   = '0;
            state_d = ST_PDU;
          end else begin
            idx_d = idx_q + 8'd1;
          end
        end
      end
      ST_PDU: begin
        cmd_o.sel     = SEL_PDU;
        cmd_o.crc_upd = !stat_i.tcp;
        cmd_o.last    = stat_i.tcp && head_end && !has_data;
        if (stat_i.can_emit) begin
          cmd_o.emit = 1'b1;
          if (head_end) begin
            idx_d = '0;
            if (has_data) state_d = ST_RDREQ;
            else if (stat_i.tcp) state_d = ST_IDLE;
            else state_d = ST_CRC;
          end else begin
            idx_d = idx_q + 8'd1;
          end
        end
      end
      ST_RDREQ: begin
        cmd_o.rd_req = 1'b1;
        state_d      = ST_DHI;
      end
      ST_DHI: begin
        cmd_o.sel     = SEL_DHI;
        cmd_o.crc_upd = !stat_i.tcp;
        if (stat_i.can_emit) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_DLO;
        end
      end
      ST_DLO: begin
        cmd_o.sel     = SEL_DLO;
        cmd_o.crc_upd = !stat_i.tcp;
        cmd_o.last    = stat_i.tcp && last_reg;
        if (stat_i.can_emit) begin
          cmd_o.emit = 1'b1;
          if (last_reg) begin
            idx_d   = '0;
            state_d = stat_i.tcp ? ST_IDLE : ST_CRC;
          end else begin
            idx_d   = idx_q + 8'd1;
            state_d = ST_RDREQ;
          end
        end
      end
      ST_CRC: begin
        cmd_o.sel  = (idx_q == 8'd0) ? SEL_CRC_LO : SEL_CRC_HI;
        cmd_o.last = (idx_q != 8'd0);
        if (stat_i.can_emit) begin
          cmd_o.emit = 1'b1;
          if (idx_q != 8'd0) state_d = ST_IDLE;
          else idx_d = 8'd1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

### rtl/core/mbshr_dp.sv
// ----------------------------------------------------------------------------
// mbshr_dp
// Datapath: config registers, frame capture and CRC, window match, register
// store and the output register.
// ----------------------------------------------------------------------------
module mbshr_dp import mbshr_pkg::*; #(
  parameter int WINDOW_DEPTH = 16,
  parameter int WINDOW_COUNT = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [4:0]  host_index_i,
  input  logic [15:0] host_data_i,
  input  cmd_t        cmd_i,
  output stat_t       stat_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  out_kind_o,
  output logic [7:0]  tx_byte_o,
  output logic        tx_last_o,
  output logic [15:0] reg_value_o,
  output logic [4:0]  reg_index_o
);

  localparam int STORE_DEPTH = WINDOW_DEPTH * WINDOW_COUNT;
  localparam int SW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  // configuration
  logic [7:0]  slave_id_q;
  logic        tcp_q;
  logic [15:0] w0_base_q, w1_base_q;
  logic [4:0]  w0_size_q, w1_size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_id_q <= 8'd1;
      tcp_q      <= 1'b0;
      w0_base_q  <= 16'd0;
      w0_size_q  <= 5'd16;
      w1_base_q  <= 16'd16;
      w1_size_q  <= 5'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SLAVE_ID: slave_id_q <= cfg_data_i[7:0];
        CFG_TCP_MODE: tcp_q      <= cfg_data_i[0];
        CFG_W0_BASE:  w0_base_q  <= cfg_data_i;
        CFG_W0_SIZE:  w0_size_q  <= cfg_data_i[4:0];
        CFG_W1_BASE:  w1_base_q  <= cfg_data_i;
        CFG_W1_SIZE:  w1_size_q  <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // frame capture
  logic [7:0]  hdr_q [HDR_DEPTH];
  logic [7:0]  byte_cnt_q, byte_cnt_d;
  logic [15:0] run_crc_q, run_crc_d;
  logic [15:0] rcv_crc_q, rcv_crc_d;
  logic        track_upd, cap_lo, cap_hi, use_lim;
  logic [8:0]  lim;

  always_ff @(posedge clk_i) begin
    if (cmd_i.link_acc && (byte_cnt_q < 8'(HDR_DEPTH))) begin
      hdr_q[byte_cnt_q[3:0]] <= rx_byte_i;
    end
  end

  // which bytes of an RTU frame feed the CRC and which carry it
  always_comb begin
    track_upd = 1'b0;
    cap_lo    = 1'b0;
    cap_hi    = 1'b0;
    use_lim   = 1'b0;
    lim       = '0;
    if (byte_cnt_q < 8'd2) begin
      track_upd = 1'b1;
    end else if (hdr_q[1] inside {[8'd1:8'd6]}) begin
      lim     = 9'd6;
      use_lim = 1'b1;
    end else if (hdr_q[1] == FN_WMC || hdr_q[1] == FN_WMR) begin
      if (byte_cnt_q <= 8'd6) begin
        track_upd = 1'b1;
      end else begin
        lim     = 9'd7 + {1'b0, hdr_q[6]};
        use_lim = 1'b1;
      end
    end
    if (use_lim) begin
      if ({1'b0, byte_cnt_q} < lim) track_upd = 1'b1;
      else if ({1'b0, byte_cnt_q} == lim) cap_lo = 1'b1;
      else if ({1'b0, byte_cnt_q} == lim + 9'd1) cap_hi = 1'b1;
    end
  end

  always_comb begin
    byte_cnt_d = byte_cnt_q;
    run_crc_d  = run_crc_q;
    rcv_crc_d  = rcv_crc_q;
    if (cmd_i.link_acc && (byte_cnt_q != 8'd255)) begin
      byte_cnt_d = byte_cnt_q + 8'd1;
      if (!tcp_q) begin
        if (track_upd) run_crc_d = crc_byte(run_crc_q, rx_byte_i);
        if (cap_lo) rcv_crc_d = {rcv_crc_q[15:8], rx_byte_i};
        if (cap_hi) rcv_crc_d = {rx_byte_i, rcv_crc_q[7:0]};
      end
    end
    if (cmd_i.latch) begin
      byte_cnt_d = '0;
      run_crc_d  = CRC_INIT;
      rcv_crc_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_cnt_q <= '0;
      run_crc_q  <= CRC_INIT;
      rcv_crc_q  <= '0;
    end else begin
      byte_cnt_q <= byte_cnt_d;
      run_crc_q  <= run_crc_d;
      rcv_crc_q  <= rcv_crc_d;
    end
  end

  // frame evaluation
  logic [7:0]    id_b, fn_b;
  logic [15:0]   r_w, v_w, q_w;
  logic          fvalid, len_ok, ok_w, is_rw, hit;
  cls_e          cls_w;
  logic [SW-1:0] bidx_w;
  logic [7:0]    fnb_w, third_w;
  logic [15:0]   plen_w;

  assign id_b   = tcp_q ? hdr_q[6] : hdr_q[0];
  assign fn_b   = tcp_q ? hdr_q[7] : hdr_q[1];
  assign r_w    = tcp_q ? {hdr_q[8], hdr_q[9]} : {hdr_q[2], hdr_q[3]};
  assign v_w    = tcp_q ? {hdr_q[10], hdr_q[11]} : {hdr_q[4], hdr_q[5]};
  assign q_w    = (fn_b == FN_READ) ? v_w : 16'd1;
  assign fvalid = (fn_b inside {[8'd1:8'd6]}) || fn_b == FN_WMC || fn_b == FN_WMR;

  always_comb begin
    if (tcp_q) len_ok = (byte_cnt_q >= 8'd12);
    else if (fn_b == FN_WMC || fn_b == FN_WMR)
      len_ok = (byte_cnt_q >= 8'd7) && ({2'b0, byte_cnt_q} >= 10'd9 + {2'b0, hdr_q[6]});
    else len_ok = (byte_cnt_q >= 8'd8);
  end

  assign ok_w = len_ok && (id_b == slave_id_q) && fvalid && (tcp_q || rcv_crc_q == run_crc_q);

  // first window that holds the whole request; unused windows are empty at base 0
  always_comb begin
    logic [15:0] wb;
    logic [7:0]  ws;
    hit    = 1'b0;
    bidx_w = '0;
    for (int w = 0; w < WINDOW_COUNT; w++) begin
      wb = 16'd0;
      ws = 8'd0;
      if (w == 0) begin
        wb = w0_base_q;
        ws = ({3'b0, w0_size_q} > 8'(WINDOW_DEPTH)) ? 8'(WINDOW_DEPTH) : {3'b0, w0_size_q};
      end
      if (w == 1) begin
        wb = w1_base_q;
        ws = ({3'b0, w1_size_q} > 8'(WINDOW_DEPTH)) ? 8'(WINDOW_DEPTH) : {3'b0, w1_size_q};
      end
      if (!hit && (r_w >= wb) &&
          ({1'b0, r_w} + {1'b0, q_w} <= {1'b0, wb} + {9'b0, ws})) begin
        hit    = 1'b1;
        bidx_w = SW'(w * WINDOW_DEPTH) + SW'(r_w - wb);
      end
    end
  end

  assign is_rw   = (fn_b == FN_READ) || (fn_b == FN_WRITE);
  assign cls_w   = (is_rw && hit) ? ((fn_b == FN_READ) ? CLS_READ : CLS_WRITE) : CLS_EXC;
  assign fnb_w   = (cls_w == CLS_READ) ? FN_READ : (fn_b | EXC_FLAG);
  assign third_w = (cls_w == CLS_READ) ? {v_w[6:0], 1'b0} : (is_rw ? EXC_ADDR : EXC_FUNC);

  always_comb begin
    case (cls_w)
      CLS_READ:  plen_w = 16'd3 + {v_w[14:0], 1'b0};
      CLS_WRITE: plen_w = 16'd6;
      default:   plen_w = 16'd3;
    endcase
  end

  logic          ok_q;
  cls_e          cls_q;
  logic [7:0]    fnb_q, third_q;
  logic [15:0]   plen_q, v_q;
  logic [SW-1:0] bidx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_q  <= 1'b0;
      cls_q <= CLS_EXC;
    end else if (cmd_i.latch) begin
      ok_q  <= ok_w;
      cls_q <= cls_w;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      fnb_q   <= fnb_w;
      third_q <= third_w;
      plen_q  <= plen_w;
      v_q     <= v_w;
      bidx_q  <= bidx_w;
    end
  end

  // register store, swept to zero after reset
  logic [SW-1:0] clr_cnt_q;
  logic          clr_done_q;
  logic          host_in_range;
  logic          ram_we, ram_re;
  logic [SW-1:0] ram_waddr, ram_raddr;
  logic [15:0]   ram_wdata, ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      clr_done_q <= 1'b0;
    end else if (cmd_i.clr_step) begin
      if (clr_cnt_q == SW'(STORE_DEPTH - 1)) clr_done_q <= 1'b1;
      else clr_cnt_q <= clr_cnt_q + SW'(1);
    end
  end

  assign host_in_range = (32'(host_index_i) < STORE_DEPTH);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_cnt_q;
    ram_wdata = '0;
    if (cmd_i.clr_step) begin
      ram_we = 1'b1;
    end else if (cmd_i.host_wr && host_in_range) begin
      ram_we    = 1'b1;
      ram_waddr = SW'(host_index_i);
      ram_wdata = host_data_i;
    end else if (cmd_i.note_wr) begin
      ram_we    = 1'b1;
      ram_waddr = bidx_q;
      ram_wdata = v_q;
    end
  end

  assign ram_re    = cmd_i.host_rd || cmd_i.rd_req;
  assign ram_raddr = cmd_i.host_rd ? SW'(host_index_i) : (bidx_q + SW'(cmd_i.idx));

  mbshr_ram #(
    .WIDTH (16),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  logic [4:0] hidx_q;
  logic       hoor_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.host_rd) begin
      hidx_q <= host_index_i;
      hoor_q <= !host_in_range;
    end
  end

  // response byte select
  logic [15:0] rcrc_q, rcrc_d;
  logic [3:0]  hix;
  logic [7:0]  hbyte, byte_w;

  assign hix   = (cmd_i.sel == SEL_HDR) ? cmd_i.idx[3:0]
               : (tcp_q ? 4'd6 + cmd_i.idx[3:0] : cmd_i.idx[3:0]);
  assign hbyte = hdr_q[hix];

  always_comb begin
    case (cmd_i.sel)
      SEL_HDR:    byte_w = hbyte;
      SEL_LEN_HI: byte_w = plen_q[15:8];
      SEL_LEN_LO: byte_w = plen_q[7:0];
      SEL_PDU: begin
        if (cls_q == CLS_WRITE || cmd_i.idx == 8'd0) byte_w = hbyte;
        else if (cmd_i.idx == 8'd1) byte_w = fnb_q;
        else byte_w = third_q;
      end
      SEL_DHI:    byte_w = ram_rdata[15:8];
      SEL_DLO:    byte_w = ram_rdata[7:0];
      SEL_CRC_LO: byte_w = rcrc_q[7:0];
      SEL_CRC_HI: byte_w = rcrc_q[15:8];
      default:    byte_w = '0;
    endcase
  end

  always_comb begin
    rcrc_d = rcrc_q;
    if (cmd_i.latch) rcrc_d = CRC_INIT;
    else if (cmd_i.emit && cmd_i.crc_upd) rcrc_d = crc_byte(rcrc_q, byte_w);
  end

  always_ff @(posedge clk_i) begin
    rcrc_q <= rcrc_d;
  end

  // output register
  logic        out_valid_q, out_valid_d;
  logic [1:0]  kind_q;
  logic [7:0]  tx_q;
  logic        last_q;
  logic [15:0] val_q;
  logic [4:0]  ridx_q;

  assign out_valid_d = cmd_i.emit ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else out_valid_q <= out_valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      kind_q <= cmd_i.kind;
      case (cmd_i.kind)
        KIND_HOST: begin
          tx_q   <= '0;
          last_q <= 1'b0;
          val_q  <= hoor_q ? 16'd0 : ram_rdata;
          ridx_q <= hidx_q;
        end
        KIND_NOTE: begin
          tx_q   <= '0;
          last_q <= 1'b0;
          val_q  <= v_q;
          ridx_q <= 5'(bidx_q);
        end
        default: begin
          tx_q   <= byte_w;
          last_q <= cmd_i.last;
          val_q  <= '0;
          ridx_q <= '0;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = kind_q;
  assign tx_byte_o   = tx_q;
  assign tx_last_o   = last_q;
  assign reg_value_o = val_q;
  assign reg_index_o = ridx_q;

  assign stat_o.clr_done = clr_done_q;
  assign stat_o.ok       = ok_q;
  assign stat_o.cls      = cls_q;
  assign stat_o.tcp      = tcp_q;
  assign stat_o.nregs    = v_q[7:0];
  assign stat_o.can_emit = !out_valid_q || out_ready_i;

endmodule

### rtl/core/modbus_slave_holding_register_engine.sv
// ----------------------------------------------------------------------------
// modbus_slave_holding_register_engine
// Modbus slave (RTU or TCP framing) serving holding-register read and write.
// ----------------------------------------------------------------------------
// Request channel (req_i): link bytes of a request frame (rx_last on the final
// byte), host register writes and host register reads. Result channel (rsp_o):
// response bytes (tx_last on the final one), host read data and a notice for
// every register the master writes, the notice ahead of the reply bytes.
// After the last frame byte the sequencer checks the frame and matches the
// windows (states CHECK and DECIDE), then response bytes leave at one per
// cycle while the receiver takes them, with a read-request step per register
// read for the store's registered read port.
// Requests are taken only when the sequencer is idle; while the receiver
// stalls, the output register holds its transaction and the sequencer waits.
// After reset the register store is swept to zero, one entry a cycle, before
// the first request is taken; configuration writes are accepted throughout.
// ----------------------------------------------------------------------------
module modbus_slave_holding_register_engine import mbshr_pkg::*; #(
  parameter int WINDOW_DEPTH = 16,
  parameter int WINDOW_COUNT = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  mbshr_req_if.sink    req_i,
  mbshr_rsp_if.source  rsp_o,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [15:0]  cfg_data_i
);

  cmd_t  cmd;
  stat_t stat;

  mbshr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .req_type_i (req_i.req_type),
    .rx_last_i  (req_i.rx_last),
    .in_ready_o (req_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mbshr_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .WINDOW_COUNT (WINDOW_COUNT)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .rx_byte_i    (req_i.rx_byte),
    .host_index_i (req_i.host_index),
    .host_data_i  (req_i.host_data),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_valid_o  (rsp_o.valid),
    .out_ready_i  (rsp_o.ready),
    .out_kind_o   (rsp_o.out_kind),
    .tx_byte_o    (rsp_o.tx_byte),
    .tx_last_o    (rsp_o.tx_last),
    .reg_value_o  (rsp_o.reg_value),
    .reg_index_o  (rsp_o.reg_index)
  );

endmodule

### rtl/core/mbshr_checker.sv
// ----------------------------------------------------------------------------
// mbshr_checker
// Port-level checks on the holding-register engine, bound to the top level.
// ----------------------------------------------------------------------------
module mbshr_checker import mbshr_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic [1:0]  req_type_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  out_kind_i,
  input logic [7:0]  tx_byte_i,
  input logic        tx_last_i,
  input logic [15:0] reg_value_i,
  input logic [4:0]  reg_index_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_kind_i) &&
      $stable(tx_byte_i) && $stable(reg_value_i))
    else $error("result changed while stalled");

  a_reg_fields_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i != KIND_TX |-> tx_byte_i == 8'd0 && !tx_last_i)
    else $error("byte fields set on a register result");

  a_byte_fields_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i == KIND_TX |-> reg_value_i == 16'd0 && reg_index_i == 5'd0)
    else $error("register fields set on a response byte");

  a_host_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && req_type_i == REQ_HRD |=> !in_ready_i)
    else $error("request taken while host read pending");

endmodule

bind modbus_slave_holding_register_engine mbshr_checker u_mbshr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_i.valid),
  .in_ready_i  (req_i.ready),
  .req_type_i  (req_i.req_type),
  .out_valid_i (rsp_o.valid),
  .out_ready_i (rsp_o.ready),
  .out_kind_i  (rsp_o.out_kind),
  .tx_byte_i   (rsp_o.tx_byte),
  .tx_last_i   (rsp_o.tx_last),
  .reg_value_i (rsp_o.reg_value),
  .reg_index_i (rsp_o.reg_index)
);
